// ===== design/lru_stat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_stat_pkg
// Shared types and codes for the access statistics table.
// ----------------------------------------------------------------------------
package lru_stat_pkg;

    // Command codes of an input word.
    localparam logic CMD_LOG   = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Result kind codes.
    localparam logic [2:0] KIND_LOG_DONE = 3'd0;
    localparam logic [2:0] KIND_FS_TOTAL = 3'd1;
    localparam logic [2:0] KIND_HANDLE   = 3'd2;
    localparam logic [2:0] KIND_FS_UNKN  = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;

    localparam int unsigned MAX_RECORDS = 16;

    typedef struct packed {
        logic        cmd;
        logic [31:0] fs_ident;
        logic [63:0] handle_key;
        logic [63:0] access_bytes;
        logic        access_kind;
        logic [4:0]  max_entries;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] handle_out;
        logic [4:0]  tracked_handles;
        logic [31:0] read_count;
        logic [31:0] write_count;
        logic [63:0] read_bytes;
        logic [63:0] write_bytes;
        logic [15:0] read_wraps;
        logic [15:0] write_wraps;
        logic        last;
    } t_out_word;

    // Counter set held per slot and per handle.
    typedef struct packed {
        logic [31:0] rd_cnt;
        logic [31:0] wr_cnt;
        logic [63:0] rd_bytes;
        logic [63:0] wr_bytes;
        logic [15:0] rd_wraps;
        logic [15:0] wr_wraps;
    } t_stats;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_UPDATE,
        ST_EMIT,
        ST_SCAN,
        ST_WAIT
    } t_state;

    // Control broadcast from the sequencer to the cell row.
    typedef struct packed {
        logic        touch;    // move target to most recent
        logic        insert;   // load key into the target cell
        logic        shift;    // rotate the row by one cell for readout
        logic        kind;     // access kind of the add
        logic [63:0] bytes;    // access size
    } t_cell_ctl;

    // Add one access to a counter set.
    function automatic t_stats stats_add(t_stats s, logic kind, logic [63:0] bytes);
        t_stats      o;
        logic [64:0] sum;
        o = s;
        if (kind == 1'b0) begin
            sum = {1'b0, s.rd_bytes} + {1'b0, bytes};
            o.rd_cnt   = s.rd_cnt + 32'd1;
            o.rd_bytes = sum[63:0];
            if (sum[64]) o.rd_wraps = s.rd_wraps + 16'd1;
        end else begin
            sum = {1'b0, s.wr_bytes} + {1'b0, bytes};
            o.wr_cnt   = s.wr_cnt + 32'd1;
            o.wr_bytes = sum[63:0];
            if (sum[64]) o.wr_wraps = s.wr_wraps + 16'd1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== design/lru_access_statistics_table.sv =====
`default_nettype none
// A log passes through the FIND, UPDATE and EMIT states and answers with one word;
// no new word is taken until the sequencer is back in idle. A fetch gives its totals
// from EMIT; the handle ring then turns one cell a cycle, holding while a record waits
// on the output, and a fetch always leaves the ring back at its home position.
// Reset clears slot valid bits and handle counts at once; no clearing pass.
// ----------------------------------------------------------------------------
// lru_access_statistics_table
// Per file system and per handle LRU access statistics with fetch readout.
// ----------------------------------------------------------------------------
module lru_access_statistics_table #(
    parameter int FS_SLOTS       = 4,
    parameter int HANDLES_PER_FS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire lru_stat_pkg::t_in_word i_data,
    output logic                      o_valid,
    input  wire                       i_ready,
    output lru_stat_pkg::t_out_word   o_data
);

    localparam int IDX_W  = $clog2(HANDLES_PER_FS);
    localparam int RANK_W = IDX_W;
    localparam int SL_W   = (FS_SLOTS > 1) ? $clog2(FS_SLOTS) : 1;

    lru_stat_pkg::t_state   r_state, n_state;
    lru_stat_pkg::t_in_word r_in;
    logic [FS_SLOTS-1:0]    r_fs_valid;
    logic [31:0]            r_fs_ident [FS_SLOTS];
    lru_stat_pkg::t_stats   r_fs_stats [FS_SLOTS];
    logic [IDX_W:0]         r_fs_count [FS_SLOTS];
    logic [SL_W-1:0]        r_slot;
    logic                   r_found;
    logic [4:0]             r_want;     // records still to emit
    logic [IDX_W:0]         r_rank_k;   // rank being looked for
    logic [IDX_W-1:0]       r_pos;      // home index of the cell at the head
    logic                   r_tgt_hit;
    logic [IDX_W-1:0]       r_target;
    logic [RANK_W-1:0]      r_tgt_rank;
    lru_stat_pkg::t_out_word r_out;
    logic                   r_out_valid;

    logic                   w_hit       [FS_SLOTS];
    logic [IDX_W-1:0]       w_hit_idx   [FS_SLOTS];
    logic [RANK_W-1:0]      w_hit_rank  [FS_SLOTS];
    logic [IDX_W-1:0]       w_lru_idx   [FS_SLOTS];
    logic [63:0]            w_head_key  [FS_SLOTS];
    logic [RANK_W-1:0]      w_head_rank [FS_SLOTS];
    lru_stat_pkg::t_stats   w_head_stats[FS_SLOTS];

    logic                   w_take_in, w_out_free;
    logic                   w_match_any, w_free_any;
    logic [SL_W-1:0]        w_match_slot, w_free_slot;
    logic                   w_do_find, w_do_update, w_do_shift;
    logic                   w_head_live, w_rec_hit;
    logic [6:0]             w_cnt_cap;
    logic                   w_emit;
    lru_stat_pkg::t_out_word w_out_next;

    assign o_ready    = (r_state == lru_stat_pkg::ST_IDLE);
    assign w_take_in  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Look up the file system slot and the lowest free slot.
    always_comb begin
        w_match_any  = 1'b0;
        w_match_slot = '0;
        w_free_any   = 1'b0;
        w_free_slot  = '0;
        for (int s = FS_SLOTS - 1; s >= 0; s--) begin
            if (r_fs_valid[s] && r_fs_ident[s] == r_in.fs_ident) begin
                w_match_any  = 1'b1;
                w_match_slot = SL_W'(s);
            end
            if (!r_fs_valid[s]) begin
                w_free_any  = 1'b1;
                w_free_slot = SL_W'(s);
            end
        end
    end

    // A record is due when a live head cell carries the rank looked for.
    assign w_head_live = (IDX_W+1)'(r_pos) < r_fs_count[r_slot];
    assign w_rec_hit   = w_head_live && ((IDX_W+1)'(w_head_rank[r_slot]) == r_rank_k);
    assign w_cnt_cap   = ({2'b0, r_in.max_entries} > 7'(r_fs_count[w_match_slot]))
                         ? 7'(r_fs_count[w_match_slot]) : {2'b0, r_in.max_entries};

    // Sequencer: next state and the find, update and shift strobes.
    always_comb begin
        n_state     = r_state;
        w_do_find   = 1'b0;
        w_do_update = 1'b0;
        w_do_shift  = 1'b0;
        case (r_state)
            lru_stat_pkg::ST_IDLE: begin
                if (w_take_in) n_state = lru_stat_pkg::ST_FIND;
            end
            lru_stat_pkg::ST_FIND: begin
                w_do_find = 1'b1;
                n_state   = lru_stat_pkg::ST_UPDATE;
            end
            lru_stat_pkg::ST_UPDATE: begin
                w_do_update = 1'b1;
                n_state     = lru_stat_pkg::ST_EMIT;
            end
            lru_stat_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    if (r_in.cmd == lru_stat_pkg::CMD_FETCH && r_found && r_want != '0)
                        n_state = lru_stat_pkg::ST_SCAN;
                    else
                        n_state = lru_stat_pkg::ST_IDLE;
                end
            end
            lru_stat_pkg::ST_SCAN: begin
                if (w_rec_hit) begin
                    if (w_out_free) begin
                        w_do_shift = 1'b1;
                        n_state = (r_want == 5'd1)
                                  ? lru_stat_pkg::ST_WAIT : lru_stat_pkg::ST_SCAN;
                    end
                end else begin
                    w_do_shift = 1'b1;
                end
            end
            lru_stat_pkg::ST_WAIT: begin
                // Finish the rotation so the ring is back in place.
                if (r_pos == '0) n_state = lru_stat_pkg::ST_IDLE;
                else w_do_shift = 1'b1;
            end
            default: n_state = lru_stat_pkg::ST_IDLE;
        endcase
    end

    // Build the next output word: first word of an item or a handle record.
    always_comb begin
        w_emit     = 1'b0;
        w_out_next = '0;
        if (r_state == lru_stat_pkg::ST_EMIT && w_out_free) begin
            w_emit          = 1'b1;
            w_out_next.last = 1'b1;
            if (r_in.cmd == lru_stat_pkg::CMD_LOG) begin
                w_out_next.kind = r_found ? lru_stat_pkg::KIND_LOG_DONE
                                          : lru_stat_pkg::KIND_FULL;
            end else if (!r_found) begin
                w_out_next.kind = lru_stat_pkg::KIND_FS_UNKN;
            end else begin
                w_out_next.kind            = lru_stat_pkg::KIND_FS_TOTAL;
                w_out_next.tracked_handles = 5'(r_fs_count[r_slot]);
                w_out_next.read_count      = r_fs_stats[r_slot].rd_cnt;
                w_out_next.write_count     = r_fs_stats[r_slot].wr_cnt;
                w_out_next.read_bytes      = r_fs_stats[r_slot].rd_bytes;
                w_out_next.write_bytes     = r_fs_stats[r_slot].wr_bytes;
                w_out_next.read_wraps      = r_fs_stats[r_slot].rd_wraps;
                w_out_next.write_wraps     = r_fs_stats[r_slot].wr_wraps;
                w_out_next.last            = (r_want == '0);
            end
        end else if (r_state == lru_stat_pkg::ST_SCAN && w_rec_hit && w_out_free) begin
            w_emit                     = 1'b1;
            w_out_next.kind            = lru_stat_pkg::KIND_HANDLE;
            w_out_next.handle_out      = w_head_key[r_slot];
            w_out_next.tracked_handles = 5'(r_fs_count[r_slot]);
            w_out_next.read_count      = w_head_stats[r_slot].rd_cnt;
            w_out_next.write_count     = w_head_stats[r_slot].wr_cnt;
            w_out_next.read_bytes      = w_head_stats[r_slot].rd_bytes;
            w_out_next.write_bytes     = w_head_stats[r_slot].wr_bytes;
            w_out_next.read_wraps      = w_head_stats[r_slot].rd_wraps;
            w_out_next.write_wraps     = w_head_stats[r_slot].wr_wraps;
            w_out_next.last            = (r_want == 5'd1);
        end
    end

    // Drive cell control per row.
    for (genvar s = 0; s < FS_SLOTS; s++) begin : g_ctl
        lru_stat_pkg::t_cell_ctl w_c;
        always_comb begin
            w_c        = '0;
            w_c.kind   = r_in.access_kind;
            w_c.bytes  = r_in.access_bytes;
            w_c.touch  = w_do_update && r_found && r_in.cmd == lru_stat_pkg::CMD_LOG
                         && r_slot == SL_W'(s);
            w_c.insert = w_c.touch && !r_tgt_hit;
            w_c.shift  = w_do_shift && r_slot == SL_W'(s);
        end
        lru_stat_row #(
            .HANDLES(HANDLES_PER_FS), .RANK_W(RANK_W), .IDX_W(IDX_W)
        ) u_row (
            .i_clk        (i_clk),
            .i_ctl        (w_c),
            .i_key        (r_in.handle_key),
            .i_count      (r_fs_count[s]),
            .i_target     (r_target),
            .i_tgt_hit    (r_tgt_hit),
            .i_tgt_rank   (r_tgt_rank),
            .o_hit        (w_hit[s]),
            .o_hit_idx    (w_hit_idx[s]),
            .o_hit_rank   (w_hit_rank[s]),
            .o_lru_idx    (w_lru_idx[s]),
            .o_head_key   (w_head_key[s]),
            .o_head_rank  (w_head_rank[s]),
            .o_head_stats (w_head_stats[s])
        );
    end

    // Registers of the sequencer and the slot table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lru_stat_pkg::ST_IDLE;
            r_fs_valid  <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < FS_SLOTS; s++) r_fs_count[s] <= '0;
        end else begin
            r_state <= n_state;
            if (w_take_in) r_in <= i_data;

            // Load the output register, or drop the word once taken.
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_out_next;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // Resolve slot, hit and target.
            if (w_do_find) begin
                r_pos    <= '0;
                r_rank_k <= '0;
                if (w_match_any) begin
                    r_found   <= 1'b1;
                    r_slot    <= w_match_slot;
                    r_want    <= (w_cnt_cap > 7'(lru_stat_pkg::MAX_RECORDS))
                                 ? 5'(lru_stat_pkg::MAX_RECORDS) : w_cnt_cap[4:0];
                    r_tgt_hit <= w_hit[w_match_slot];
                    r_tgt_rank <= w_hit_rank[w_match_slot];
                    if (w_hit[w_match_slot])
                        r_target <= w_hit_idx[w_match_slot];
                    else if (r_fs_count[w_match_slot] < (IDX_W+1)'(HANDLES_PER_FS))
                        r_target <= r_fs_count[w_match_slot][IDX_W-1:0];
                    else
                        r_target <= w_lru_idx[w_match_slot];
                end else if (r_in.cmd == lru_stat_pkg::CMD_LOG && w_free_any) begin
                    // Create the slot with an empty table.
                    r_found    <= 1'b1;
                    r_slot     <= w_free_slot;
                    r_want     <= '0;
                    r_tgt_hit  <= 1'b0;
                    r_tgt_rank <= '0;
                    r_target   <= '0;
                    r_fs_valid[w_free_slot] <= 1'b1;
                    r_fs_ident[w_free_slot] <= r_in.fs_ident;
                    r_fs_stats[w_free_slot] <= '0;
                    r_fs_count[w_free_slot] <= '0;
                end else begin
                    r_found <= 1'b0;
                    r_want  <= '0;
                end
            end

            // Apply the log to the slot totals and count.
            if (w_do_update && r_found && r_in.cmd == lru_stat_pkg::CMD_LOG) begin
                r_fs_stats[r_slot] <= lru_stat_pkg::stats_add(r_fs_stats[r_slot],
                                      r_in.access_kind, r_in.access_bytes);
                if (!r_tgt_hit && r_fs_count[r_slot] < (IDX_W+1)'(HANDLES_PER_FS))
                    r_fs_count[r_slot] <= r_fs_count[r_slot] + (IDX_W+1)'(1);
            end

            // Advance the head position; step to the next rank after a record.
            if (w_do_shift)
                r_pos <= (r_pos == IDX_W'(HANDLES_PER_FS - 1)) ? '0 : r_pos + IDX_W'(1);
            if (r_state == lru_stat_pkg::ST_SCAN && w_emit) begin
                r_want   <= r_want - 5'd1;
                r_rank_k <= r_rank_k + (IDX_W+1)'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    // Input is never taken while the ring is being scanned.
    a_no_out_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |-> !(r_state == lru_stat_pkg::ST_SCAN)) else $error("take in scan");
    // The handle count of slot 0 never exceeds the table size.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fs_count[0] <= (IDX_W+1)'(HANDLES_PER_FS)) else $error("count overflow");
    // Hold a waiting output word unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data))) else $error("output dropped");
`endif

endmodule
`default_nettype wire

// ===== design/lru_stat_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_stat_cell
// One handle entry: key, recency rank, counters. Compares against the key
// broadcast, ages on a touch, and hands its contents to its neighbor on a
// readout rotation.
// ----------------------------------------------------------------------------
module lru_stat_cell #(
    parameter int RANK_W = 4
) (
    input  wire                       i_clk,
    input  wire lru_stat_pkg::t_cell_ctl i_ctl,
    input  wire [63:0]                i_key,
    input  wire                       i_live,        // cell index below count
    input  wire                       i_target,      // this cell is the target
    input  wire [RANK_W-1:0]          i_tgt_rank,    // old rank of the target
    input  wire                       i_tgt_hit,     // target was a hit
    input  wire [63:0]                i_nb_key,
    input  wire [RANK_W-1:0]          i_nb_rank,
    input  wire lru_stat_pkg::t_stats i_nb_stats,
    output logic                      o_match,
    output logic [63:0]               o_key,
    output logic [RANK_W-1:0]         o_rank,
    output lru_stat_pkg::t_stats      o_stats
);

    logic [63:0]          r_key;
    logic [RANK_W-1:0]    r_rank;
    lru_stat_pkg::t_stats r_stats;

    // Flag a key match on a live cell.
    assign o_match = i_live && (r_key == i_key);
    assign o_key   = r_key;
    assign o_rank  = r_rank;
    assign o_stats = r_stats;

    // Update rank, key and counters.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_nb_key;
            r_rank  <= i_nb_rank;
            r_stats <= i_nb_stats;
        end else if (i_ctl.touch) begin
            if (i_target) begin
                r_rank <= '0;
                if (i_ctl.insert) begin
                    r_key <= i_key;
                end
                if (i_ctl.insert) begin
                    r_stats <= lru_stat_pkg::stats_add('0, i_ctl.kind, i_ctl.bytes);
                end else begin
                    r_stats <= lru_stat_pkg::stats_add(r_stats, i_ctl.kind, i_ctl.bytes);
                end
            end else if (i_live) begin
                // Age every younger entry on a hit, every entry on a miss.
                if (!i_tgt_hit || r_rank < i_tgt_rank) begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/lru_stat_row.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_stat_row
// Handle table of one file system slot: a ring of cells. A readout rotates the
// ring one cell a cycle while shift is set, so cell 0 presents each entry in turn.
// ----------------------------------------------------------------------------
module lru_stat_row #(
    parameter int HANDLES = 16,
    parameter int RANK_W  = 4,
    parameter int IDX_W   = 4
) (
    input  wire                       i_clk,
    input  wire lru_stat_pkg::t_cell_ctl i_ctl,
    input  wire [63:0]                i_key,
    input  wire [IDX_W:0]             i_count,
    input  wire [IDX_W-1:0]           i_target,
    input  wire                       i_tgt_hit,
    input  wire [RANK_W-1:0]          i_tgt_rank,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_hit_idx,
    output logic [RANK_W-1:0]         o_hit_rank,
    output logic [IDX_W-1:0]          o_lru_idx,
    output logic [63:0]               o_head_key,
    output logic [RANK_W-1:0]         o_head_rank,
    output lru_stat_pkg::t_stats      o_head_stats
);

    logic [HANDLES-1:0]      w_match;
    logic [63:0]             w_key   [HANDLES];
    logic [RANK_W-1:0]       w_rank  [HANDLES];
    lru_stat_pkg::t_stats    w_stats [HANDLES];

    // Build the ring of cells.
    for (genvar g = 0; g < HANDLES; g++) begin : g_cell
        localparam int NB = (g + 1) % HANDLES;
        lru_stat_cell #(.RANK_W(RANK_W)) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_key      (i_key),
            .i_live     ((IDX_W+1)'(g) < i_count),
            .i_target   (i_target == IDX_W'(g)),
            .i_tgt_rank (i_tgt_rank),
            .i_tgt_hit  (i_tgt_hit),
            .i_nb_key   (w_key[NB]),
            .i_nb_rank  (w_rank[NB]),
            .i_nb_stats (w_stats[NB]),
            .o_match    (w_match[g]),
            .o_key      (w_key[g]),
            .o_rank     (w_rank[g]),
            .o_stats    (w_stats[g])
        );
    end

    // Pick the first matching cell and the least recent cell.
    always_comb begin
        o_hit      = 1'b0;
        o_hit_idx  = '0;
        o_hit_rank = '0;
        o_lru_idx  = '0;
        for (int i = HANDLES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_hit      = 1'b1;
                o_hit_idx  = IDX_W'(i);
                o_hit_rank = w_rank[i];
            end
            if (w_rank[i] == RANK_W'(HANDLES - 1)) begin
                o_lru_idx = IDX_W'(i);
            end
        end
    end

    assign o_head_key   = w_key[0];
    assign o_head_rank  = w_rank[0];
    assign o_head_stats = w_stats[0];

endmodule
`default_nettype wire
